### rtl/core/vsam_pkg.sv
// Shared types and constants of the vital-sign alarm monitor.
package vsam_pkg;

  // Field widths
  localparam int unsigned RATE_W = 8;
  localparam int unsigned TEMP_W = 13;
  localparam int unsigned OXY_W  = 7;
  localparam int unsigned CODE_W = 3;
  localparam int unsigned PRIO_W = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  // Default window depth
  localparam int unsigned WINDOW_DEPTH_DEF = 10;

  // Saturation bounds
  localparam logic [RATE_W-1:0] RATE_MIN = RATE_W'(50);
  localparam logic [RATE_W-1:0] RATE_MAX = RATE_W'(200);
  localparam logic [TEMP_W-1:0] TEMP_MIN = TEMP_W'(3500);
  localparam logic [TEMP_W-1:0] TEMP_MAX = TEMP_W'(4100);
  localparam logic [OXY_W-1:0]  OXY_MIN  = OXY_W'(80);
  localparam logic [OXY_W-1:0]  OXY_MAX  = OXY_W'(100);

  // Heart-rate band edges
  localparam logic [RATE_W-1:0] RATE_LOW_EDGE  = RATE_W'(70);
  localparam logic [RATE_W-1:0] RATE_BAND_LO   = RATE_W'(80);
  localparam logic [RATE_W-1:0] RATE_BAND_HI   = RATE_W'(140);
  localparam logic [RATE_W-1:0] RATE_HIGH_EDGE = RATE_W'(160);

  // Register reset values
  localparam logic              AUTO_RST     = 1'b1;
  localparam logic              AGE_RST      = 1'b1;
  localparam logic [OXY_W-1:0]  OXY_LIM_RST  = OXY_W'(92);
  localparam logic [TEMP_W-1:0] TEMP_LIM_RST = TEMP_W'(3750);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AGE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OXY_LIM  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LIM = 2'd3;

  // Item modes
  localparam logic MODE_VITAL  = 1'b0;
  localparam logic MODE_ACTION = 1'b1;

  // Action codes
  localparam logic [CODE_W-1:0] ACT_FALL   = 3'd1;
  localparam logic [CODE_W-1:0] ACT_OXYGEN = 3'd2;
  localparam logic [CODE_W-1:0] ACT_TEMP   = 3'd3;
  localparam logic [CODE_W-1:0] ACT_HEART  = 3'd4;
  localparam logic [CODE_W-1:0] ACT_MANUAL = 3'd5;

  // Priorities
  localparam logic [PRIO_W-1:0] PRIO_NONE = 3'd0;
  localparam logic [PRIO_W-1:0] PRIO_LOW  = 3'd1;
  localparam logic [PRIO_W-1:0] PRIO_MID  = 3'd2;
  localparam logic [PRIO_W-1:0] PRIO_OXY  = 3'd3;
  localparam logic [PRIO_W-1:0] PRIO_TEMP = 3'd4;

  // Window control from the evaluator
  typedef struct packed {
    logic push;
    logic clear;
  } win_ctrl_t;

endpackage

### rtl/core/vital_sign_alarm_monitor.sv
// Top level of the vital-sign alarm monitor: input register, evaluation, result register.
//
//  channel | direction | transfer when             | payload
//  in      | input     | in_valid_i & !in_stall_o  | mode, heart rate, temp, oxygen, action
//  out     | output    | out_valid_o & !out_stall_i| readings, four alarm flags, priority
//  cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// One item per cycle unless in_stall_o is high; records leave from the result register.
// The whole evaluation is one pass between the input and result registers; the window
// sums are kept running, so no step walks the window.
// Reset zeroes windows and readings, presets cfg registers at once; no clearing pass.
// While a record waits on out_stall_i, items that yield no record keep moving, and one
// more item is held in the input register.
module vital_sign_alarm_monitor #(
  parameter int unsigned WINDOW_DEPTH = vsam_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [vsam_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [vsam_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           mode_i,
  input  logic [vsam_pkg::RATE_W-1:0]     heart_rate_i,
  input  logic [vsam_pkg::TEMP_W-1:0]     body_temp_centi_i,
  input  logic [vsam_pkg::OXY_W-1:0]      oxygenation_i,
  input  logic [vsam_pkg::CODE_W-1:0]     action_code_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [vsam_pkg::RATE_W-1:0]     rate_reading_o,
  output logic [vsam_pkg::TEMP_W-1:0]     temp_reading_o,
  output logic [vsam_pkg::OXY_W-1:0]      oxygen_reading_o,
  output logic                           fall_alarm_o,
  output logic                           heart_alarm_o,
  output logic                           temp_alarm_o,
  output logic                           oxygen_alarm_o,
  output logic [vsam_pkg::PRIO_W-1:0]     alarm_priority_o
);
  import vsam_pkg::*;

  localparam int unsigned TSUM_W = TEMP_W + $clog2(WINDOW_DEPTH);
  localparam int unsigned OSUM_W = OXY_W + $clog2(WINDOW_DEPTH);

  // Configuration registers
  logic              auto_q, age_q;
  logic [OXY_W-1:0]  oxy_lim_q;
  logic [TEMP_W-1:0] temp_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_q     <= AUTO_RST;
      age_q      <= AGE_RST;
      oxy_lim_q  <= OXY_LIM_RST;
      temp_lim_q <= TEMP_LIM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_AUTO:     auto_q     <= cfg_wdata_i[0];
        CFG_AGE:      age_q      <= cfg_wdata_i[0];
        CFG_OXY_LIM:  oxy_lim_q  <= cfg_wdata_i[OXY_W-1:0];
        CFG_TEMP_LIM: temp_lim_q <= cfg_wdata_i[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic              in_valid_q;
  logic              mode_q;
  logic [RATE_W-1:0] rate_in_q;
  logic [TEMP_W-1:0] temp_in_q;
  logic [OXY_W-1:0]  oxy_in_q;
  logic [CODE_W-1:0] code_q;
  logic              in_xfer, fire;

  assign in_stall_o = in_valid_q && !fire;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mode_q    <= mode_i;
      rate_in_q <= heart_rate_i;
      temp_in_q <= body_temp_centi_i;
      oxy_in_q  <= oxygenation_i;
      code_q    <= action_code_i;
    end
  end

  // Saturation
  logic [RATE_W-1:0] rate_sat;
  logic [TEMP_W-1:0] temp_sat;
  logic [OXY_W-1:0]  oxy_sat;

  assign rate_sat = (rate_in_q < RATE_MIN) ? RATE_MIN :
                    (rate_in_q > RATE_MAX) ? RATE_MAX : rate_in_q;
  assign temp_sat = (temp_in_q < TEMP_MIN) ? TEMP_MIN :
                    (temp_in_q > TEMP_MAX) ? TEMP_MAX : temp_in_q;
  assign oxy_sat  = (oxy_in_q < OXY_MIN) ? OXY_MIN :
                    (oxy_in_q > OXY_MAX) ? OXY_MAX : oxy_in_q;

  // Windows
  win_ctrl_t         t_ctrl, o_ctrl;
  logic              t_full_next, o_full_next;
  logic [TSUM_W-1:0] t_sum_next;
  logic [OSUM_W-1:0] o_sum_next;

  vsam_window #(
    .DATA_W(TEMP_W), .DEPTH(WINDOW_DEPTH), .SUM_W(TSUM_W)
  ) u_temp_win (
    .clk_i, .rst_ni, .ctrl_i(t_ctrl), .data_i(temp_sat),
    .full_next_o(t_full_next), .sum_next_o(t_sum_next)
  );

  vsam_window #(
    .DATA_W(OXY_W), .DEPTH(WINDOW_DEPTH), .SUM_W(OSUM_W)
  ) u_oxy_win (
    .clk_i, .rst_ni, .ctrl_i(o_ctrl), .data_i(oxy_sat),
    .full_next_o(o_full_next), .sum_next_o(o_sum_next)
  );

  // Alarm evaluation
  logic              is_vital, act_ok, has_result;
  logic              heart_alm, oxy_alm, temp_alm;
  logic [PRIO_W-1:0] heart_prio, auto_prio;

  assign is_vital = (mode_q == MODE_VITAL);

  assign oxy_alm  = auto_q && o_full_next &&
                    (o_sum_next < OSUM_W'(oxy_lim_q) * OSUM_W'(WINDOW_DEPTH));
  assign temp_alm = auto_q && t_full_next &&
                    (t_sum_next > TSUM_W'(temp_lim_q) * TSUM_W'(WINDOW_DEPTH));

  // Heart band
  always_comb begin
    heart_alm  = 1'b0;
    heart_prio = PRIO_NONE;
    if (auto_q && age_q) begin
      heart_alm = !((rate_sat > RATE_BAND_LO) && (rate_sat < RATE_BAND_HI));
      if (rate_sat <= RATE_LOW_EDGE)      heart_prio = PRIO_LOW;
      else if (rate_sat <= RATE_BAND_LO)  heart_prio = PRIO_MID;
      else if (rate_sat < RATE_BAND_HI)   heart_prio = PRIO_NONE;
      else if (rate_sat < RATE_HIGH_EDGE) heart_prio = PRIO_MID;
      else                                heart_prio = PRIO_LOW;
    end
  end

  // Later rules win: temperature over oxygen over heart
  assign auto_prio = temp_alm ? PRIO_TEMP : oxy_alm ? PRIO_OXY : heart_prio;

  always_comb begin
    case (code_q) inside
      ACT_FALL, ACT_OXYGEN, ACT_TEMP, ACT_HEART, ACT_MANUAL: act_ok = 1'b1;
      default: act_ok = 1'b0;
    endcase
  end

  assign has_result = is_vital ? (heart_alm || oxy_alm || temp_alm) : act_ok;

  // Output register
  logic              out_valid_q;
  logic [RATE_W-1:0] last_rate_q;
  logic [TEMP_W-1:0] last_temp_q;
  logic [OXY_W-1:0]  last_oxy_q;
  logic [RATE_W-1:0] rec_rate_q;
  logic [TEMP_W-1:0] rec_temp_q;
  logic [OXY_W-1:0]  rec_oxy_q;
  logic              fall_q, heart_q, temp_q, oxy_q;
  logic [PRIO_W-1:0] prio_q;
  logic              emit;

  // An item moves on unless it has a record and the result register is held
  assign fire = in_valid_q && (!has_result || !out_valid_q || !out_stall_i);
  assign emit = fire && has_result;

  assign t_ctrl.push  = fire && is_vital;
  assign t_ctrl.clear = fire && is_vital && temp_alm;
  assign o_ctrl.push  = fire && is_vital;
  assign o_ctrl.clear = fire && is_vital && oxy_alm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      last_rate_q <= '0;
      last_temp_q <= '0;
      last_oxy_q  <= '0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (fire && is_vital) begin
        last_rate_q <= rate_sat;
        last_temp_q <= temp_sat;
        last_oxy_q  <= oxy_sat;
      end
    end
  end

  // Record fields; readings are captured with the record so a held record keeps them
  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (is_vital) begin
        rec_rate_q <= rate_sat;
        rec_temp_q <= temp_sat;
        rec_oxy_q  <= oxy_sat;
        fall_q     <= 1'b0;
        heart_q    <= heart_alm;
        temp_q     <= temp_alm;
        oxy_q      <= oxy_alm;
        prio_q     <= auto_prio;
      end else begin
        rec_rate_q <= last_rate_q;
        rec_temp_q <= last_temp_q;
        rec_oxy_q  <= last_oxy_q;
        fall_q     <= (code_q == ACT_FALL);
        heart_q    <= (code_q == ACT_HEART);
        temp_q     <= (code_q == ACT_TEMP);
        oxy_q      <= (code_q == ACT_OXYGEN);
        prio_q     <= (code_q == ACT_MANUAL) ? PRIO_NONE : PRIO_LOW;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign rate_reading_o   = rec_rate_q;
  assign temp_reading_o   = rec_temp_q;
  assign oxygen_reading_o = rec_oxy_q;
  assign fall_alarm_o     = fall_q;
  assign heart_alarm_o    = heart_q;
  assign temp_alarm_o     = temp_q;
  assign oxygen_alarm_o   = oxy_q;
  assign alarm_priority_o = prio_q;

`ifndef SYNTHESIS
  // A cleared window cannot report full on the next sample
  a_temp_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    t_ctrl.clear |=> !t_full_next)
    else $error("temperature window full right after clear");

  a_oxy_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_ctrl.clear |=> !o_full_next)
    else $error("oxygen window full right after clear");

  // A fall record carries only the fall flag at low priority
  a_fall_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fall_alarm_o) |->
      (!heart_alarm_o && !temp_alarm_o && !oxygen_alarm_o && alarm_priority_o == PRIO_LOW))
    else $error("fall record with other flags or wrong priority");
`endif

endmodule

### rtl/core/vsam_window.sv
// Sample window: shift line with a running sum and a full indication.
module vsam_window #(
  parameter int unsigned DATA_W = vsam_pkg::TEMP_W,
  parameter int unsigned DEPTH  = vsam_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned SUM_W  = DATA_W + $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vsam_pkg::win_ctrl_t ctrl_i,
  input  logic [DATA_W-1:0]   data_i,
  output logic                full_next_o,
  output logic [SUM_W-1:0]    sum_next_o
);
  import vsam_pkg::*;

  logic [DATA_W-1:0] taps_q [DEPTH];
  logic [SUM_W-1:0]  sum_q;

  // Window as it would stand once data_i has entered
  assign sum_next_o  = sum_q + SUM_W'(data_i) - SUM_W'(taps_q[DEPTH-1]);
  assign full_next_o = (taps_q[DEPTH-2] != '0);

  // Shift in on push, zero everything on clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) taps_q[k] <= '0;
      sum_q <= '0;
    end else if (ctrl_i.clear) begin
      for (int k = 0; k < DEPTH; k++) taps_q[k] <= '0;
      sum_q <= '0;
    end else if (ctrl_i.push) begin
      taps_q[0] <= data_i;
      for (int k = 1; k < DEPTH; k++) taps_q[k] <= taps_q[k-1];
      sum_q <= sum_next_o;
    end
  end

endmodule

### tb/vital_sign_alarm_monitor_tb.sv
// Self-checking testbench of the vital-sign alarm monitor: directed table, then random phases.
module vital_sign_alarm_monitor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vsam_pkg::*;

  localparam int unsigned WIN            = WINDOW_DEPTH_DEF;
  localparam int unsigned N_PHASES       = 7;
  localparam int unsigned ITEMS_PER_PH   = 200;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned RESET_CYCLES   = 6;
  localparam int unsigned CYCLE_LIMIT    = 300000;

  // One alarm record as it leaves the block
  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [TEMP_W-1:0] temp;
    logic [OXY_W-1:0]  oxygen;
    logic              fall;
    logic              heart;
    logic              hot;
    logic              low_oxy;
    logic [PRIO_W-1:0] prio;
  } alarm_rec_t;

  // How a stimulus row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_RECORD,
    CHK_SILENT
  } chk_kind_t;

  typedef struct packed {
    logic              mode;
    logic [RATE_W-1:0] hr;
    logic [TEMP_W-1:0] tc;
    logic [OXY_W-1:0]  ox;
    logic [CODE_W-1:0] code;
    chk_kind_t         kind;
    alarm_rec_t        rec;
  } vital_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_stall_o;
  logic mode_i;
  logic [RATE_W-1:0] heart_rate_i;
  logic [TEMP_W-1:0] body_temp_centi_i;
  logic [OXY_W-1:0]  oxygenation_i;
  logic [CODE_W-1:0] action_code_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [RATE_W-1:0] rate_reading_o;
  logic [TEMP_W-1:0] temp_reading_o;
  logic [OXY_W-1:0]  oxygen_reading_o;
  logic fall_alarm_o;
  logic heart_alarm_o;
  logic temp_alarm_o;
  logic oxygen_alarm_o;
  logic [PRIO_W-1:0] alarm_priority_o;

  // Predictor copy of settings and state
  logic              m_auto;
  logic              m_age;
  logic [OXY_W-1:0]  m_oxy_lim;
  logic [TEMP_W-1:0] m_temp_lim;
  logic [TEMP_W-1:0] temp_win [WIN];
  logic [OXY_W-1:0]  oxy_win [WIN];
  int unsigned       temp_pos;
  int unsigned       oxy_pos;
  logic [RATE_W-1:0] cur_rate;
  logic [TEMP_W-1:0] cur_temp;
  logic [OXY_W-1:0]  cur_oxy;

  alarm_rec_t  expected_alarms [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          quiet = 1'b0;
  bit          pressure_go = 1'b0;
  bit          pressure_done = 1'b0;
  chk_kind_t   row_kind;
  alarm_rec_t  row_rec;

  vital_sign_alarm_monitor #(
    .WINDOW_DEPTH(WIN)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .mode_i            (mode_i),
    .heart_rate_i      (heart_rate_i),
    .body_temp_centi_i (body_temp_centi_i),
    .oxygenation_i     (oxygenation_i),
    .action_code_i     (action_code_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .rate_reading_o    (rate_reading_o),
    .temp_reading_o    (temp_reading_o),
    .oxygen_reading_o  (oxygen_reading_o),
    .fall_alarm_o      (fall_alarm_o),
    .heart_alarm_o     (heart_alarm_o),
    .temp_alarm_o      (temp_alarm_o),
    .oxygen_alarm_o    (oxygen_alarm_o),
    .alarm_priority_o  (alarm_priority_o)
  );

  // Clock, 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic note_mismatch(input string msg);
    $display("mismatch @%0d: %s", cycles, msg);
    errors = errors + 1;
  endtask

  function automatic int unsigned clip(input int unsigned v, input int unsigned lo,
                                       input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic reset_model();
    m_auto     = AUTO_RST;
    m_age      = AGE_RST;
    m_oxy_lim  = OXY_LIM_RST;
    m_temp_lim = TEMP_LIM_RST;
    foreach (temp_win[i]) temp_win[i] = '0;
    foreach (oxy_win[i]) oxy_win[i] = '0;
    temp_pos = 0;
    oxy_pos  = 0;
    cur_rate = '0;
    cur_temp = '0;
    cur_oxy  = '0;
  endtask

  // Advance the predictor by one accepted item; returns 1 when a record is due
  function automatic bit predict_alarm(input logic mode, input logic [RATE_W-1:0] hr,
                                       input logic [TEMP_W-1:0] tc, input logic [OXY_W-1:0] ox,
                                       input logic [CODE_W-1:0] code, output alarm_rec_t rec);
    int unsigned osum;
    int unsigned tsum;
    rec = '0;
    osum = 0;
    tsum = 0;
    if (mode == MODE_ACTION) begin
      // codes outside fall..manual are dropped without effect
      if (code < ACT_FALL || code > ACT_MANUAL) return 1'b0;
      rec.rate    = cur_rate;
      rec.temp    = cur_temp;
      rec.oxygen  = cur_oxy;
      rec.fall    = (code == ACT_FALL);
      rec.heart   = (code == ACT_HEART);
      rec.hot     = (code == ACT_TEMP);
      rec.low_oxy = (code == ACT_OXYGEN);
      rec.prio    = (code == ACT_MANUAL) ? PRIO_NONE : PRIO_LOW;
      return 1'b1;
    end

    // saturate and store readings, push into both windows
    cur_rate = RATE_W'(clip(hr, RATE_MIN, RATE_MAX));
    cur_temp = TEMP_W'(clip(tc, TEMP_MIN, TEMP_MAX));
    cur_oxy  = OXY_W'(clip(ox, OXY_MIN, OXY_MAX));
    temp_win[temp_pos] = cur_temp;
    temp_pos = (temp_pos + 1) % WIN;
    oxy_win[oxy_pos] = cur_oxy;
    oxy_pos = (oxy_pos + 1) % WIN;
    rec.rate   = cur_rate;
    rec.temp   = cur_temp;
    rec.oxygen = cur_oxy;
    rec.prio   = PRIO_NONE;
    if (!m_auto) return 1'b0;

    // heart-rate band
    if (m_age) begin
      rec.heart = !(cur_rate > RATE_BAND_LO && cur_rate < RATE_BAND_HI);
      if (cur_rate > RATE_LOW_EDGE && cur_rate <= RATE_BAND_LO) rec.prio = PRIO_MID;
      else if (cur_rate <= RATE_LOW_EDGE) rec.prio = PRIO_LOW;
      else if (cur_rate >= RATE_BAND_HI && cur_rate < RATE_HIGH_EDGE) rec.prio = PRIO_MID;
      else if (cur_rate >= RATE_HIGH_EDGE) rec.prio = PRIO_LOW;
    end

    // oxygen window, only once full
    if (oxy_win[WIN-1] != '0) begin
      foreach (oxy_win[i]) osum += oxy_win[i];
      if (osum < int'(m_oxy_lim) * WIN) begin
        rec.low_oxy = 1'b1;
        rec.prio    = PRIO_OXY;
        foreach (oxy_win[i]) oxy_win[i] = '0;
        oxy_pos = 0;
      end
    end

    // temperature window, checked after oxygen
    if (temp_win[WIN-1] != '0) begin
      foreach (temp_win[i]) tsum += temp_win[i];
      if (tsum > int'(m_temp_lim) * WIN) begin
        rec.hot  = 1'b1;
        rec.prio = PRIO_TEMP;
        foreach (temp_win[i]) temp_win[i] = '0;
        temp_pos = 0;
      end
    end

    return rec.heart || rec.low_oxy || rec.hot;
  endfunction

  task automatic compare_record(input alarm_rec_t got, input alarm_rec_t want);
    if (got.rate !== want.rate)
      note_mismatch($sformatf("rate_reading %0d, want %0d", got.rate, want.rate));
    if (got.temp !== want.temp)
      note_mismatch($sformatf("temp_reading %0d, want %0d", got.temp, want.temp));
    if (got.oxygen !== want.oxygen)
      note_mismatch($sformatf("oxygen_reading %0d, want %0d", got.oxygen, want.oxygen));
    if (got.fall !== want.fall)
      note_mismatch($sformatf("fall_alarm %0b, want %0b", got.fall, want.fall));
    if (got.heart !== want.heart)
      note_mismatch($sformatf("heart_alarm %0b, want %0b", got.heart, want.heart));
    if (got.hot !== want.hot)
      note_mismatch($sformatf("temp_alarm %0b, want %0b", got.hot, want.hot));
    if (got.low_oxy !== want.low_oxy)
      note_mismatch($sformatf("oxygen_alarm %0b, want %0b", got.low_oxy, want.low_oxy));
    if (got.prio !== want.prio)
      note_mismatch($sformatf("alarm_priority %0d, want %0d", got.prio, want.prio));
  endtask

  // Monitor: outputs first, then register writes, then input transfers
  always @(posedge clk_i) begin
    alarm_rec_t got;
    alarm_rec_t want;
    bit         due;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.rate    = rate_reading_o;
        got.temp    = temp_reading_o;
        got.oxygen  = oxygen_reading_o;
        got.fall    = fall_alarm_o;
        got.heart   = heart_alarm_o;
        got.hot     = temp_alarm_o;
        got.low_oxy = oxygen_alarm_o;
        got.prio    = alarm_priority_o;
        if (expected_alarms.size() == 0) begin
          note_mismatch($sformatf("record with none expected, priority %0d", got.prio));
        end else begin
          compare_record(got, expected_alarms.pop_front());
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_AUTO:     m_auto     = cfg_wdata_i[0];
          CFG_AGE:      m_age      = cfg_wdata_i[0];
          CFG_OXY_LIM:  m_oxy_lim  = cfg_wdata_i[OXY_W-1:0];
          CFG_TEMP_LIM: m_temp_lim = cfg_wdata_i[TEMP_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        due = predict_alarm(mode_i, heart_rate_i, body_temp_centi_i, oxygenation_i,
                            action_code_i, want);
        case (row_kind)
          CHK_MODEL:  if (due) expected_alarms.push_back(want);
          CHK_RECORD: expected_alarms.push_back(row_rec);
          default: ;
        endcase
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off, none at the end
  initial begin : receiver
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (quiet) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else if (pressure_go && !pressure_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        pressure_done = 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 30);
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
    end
  end

  function automatic alarm_rec_t mk_rec(input logic [RATE_W-1:0] rate,
                                        input logic [TEMP_W-1:0] temp,
                                        input logic [OXY_W-1:0] oxygen, input logic fall,
                                        input logic heart, input logic hot, input logic low_oxy,
                                        input logic [PRIO_W-1:0] prio);
    alarm_rec_t r;
    r.rate    = rate;
    r.temp    = temp;
    r.oxygen  = oxygen;
    r.fall    = fall;
    r.heart   = heart;
    r.hot     = hot;
    r.low_oxy = low_oxy;
    r.prio    = prio;
    return r;
  endfunction

  function automatic vital_item_t mk_item(input logic mode, input logic [RATE_W-1:0] hr,
                                          input logic [TEMP_W-1:0] tc,
                                          input logic [OXY_W-1:0] ox,
                                          input logic [CODE_W-1:0] code, input chk_kind_t kind,
                                          input alarm_rec_t rec);
    vital_item_t it;
    it.mode = mode;
    it.hr   = hr;
    it.tc   = tc;
    it.ox   = ox;
    it.code = code;
    it.kind = kind;
    it.rec  = rec;
    return it;
  endfunction

  // Mostly plausible vitals with random content, some actions, some full-range noise
  function automatic vital_item_t random_item();
    vital_item_t it;
    int unsigned pick;
    it      = '0;
    it.kind = CHK_MODEL;
    it.hr   = RATE_W'($urandom);
    it.tc   = TEMP_W'($urandom);
    it.ox   = OXY_W'($urandom);
    it.code = CODE_W'($urandom);
    pick    = $urandom_range(0, 99);
    if (pick < 20) begin
      it.mode = MODE_ACTION;
    end else begin
      it.mode = MODE_VITAL;
      if (pick >= 30) begin
        it.hr = RATE_W'($urandom_range(45, 210));
        it.tc = TEMP_W'($urandom_range(3450, 4150));
        it.ox = OXY_W'($urandom_range(76, 104));
      end
    end
    return it;
  endfunction

  // Present one item and hold it until the transfer
  task automatic offer(input vital_item_t it);
    in_valid_i        <= 1'b1;
    mode_i            <= it.mode;
    heart_rate_i      <= it.hr;
    body_temp_centi_i <= it.tc;
    oxygenation_i     <= it.ox;
    action_code_i     <= it.code;
    row_kind          <= it.kind;
    row_rec           <= it.rec;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 99) < 15) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  // Drain all outstanding records plus the pipeline of silent items
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_alarms.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic load_settings(input logic auto_on, input logic age_on,
                               input logic [OXY_W-1:0] olim, input logic [TEMP_W-1:0] tlim);
    wait_idle();
    write_cfg(CFG_AUTO, CFG_DATA_W'(auto_on));
    write_cfg(CFG_AGE, CFG_DATA_W'(age_on));
    write_cfg(CFG_OXY_LIM, CFG_DATA_W'(olim));
    write_cfg(CFG_TEMP_LIM, CFG_DATA_W'(tlim));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stimulus
  initial begin : stimulus
    vital_item_t dir_rows [$];
    alarm_rec_t  none;
    none              = '0;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_wdata_i       = '0;
    in_valid_i        = 1'b0;
    mode_i            = MODE_VITAL;
    heart_rate_i      = '0;
    body_temp_centi_i = '0;
    oxygenation_i     = '0;
    action_code_i     = '0;
    row_kind          = CHK_MODEL;
    row_rec           = '0;
    reset_model();

    // actions right after reset report zero readings; payload of an action is ignored
    dir_rows.push_back(mk_item(MODE_ACTION, 0, 0, 0, ACT_MANUAL, CHK_RECORD,
                               mk_rec(0, 0, 0, 0, 0, 0, 0, PRIO_NONE)));
    dir_rows.push_back(mk_item(MODE_ACTION, 255, 8191, 127, ACT_FALL, CHK_RECORD,
                               mk_rec(0, 0, 0, 1, 0, 0, 0, PRIO_LOW)));
    dir_rows.push_back(mk_item(MODE_ACTION, 0, 0, 0, ACT_OXYGEN, CHK_RECORD,
                               mk_rec(0, 0, 0, 0, 0, 0, 1, PRIO_LOW)));
    dir_rows.push_back(mk_item(MODE_ACTION, 0, 0, 0, ACT_TEMP, CHK_RECORD,
                               mk_rec(0, 0, 0, 0, 0, 1, 0, PRIO_LOW)));
    dir_rows.push_back(mk_item(MODE_ACTION, 0, 0, 0, ACT_HEART, CHK_RECORD,
                               mk_rec(0, 0, 0, 0, 1, 0, 0, PRIO_LOW)));
    // unused action codes produce nothing
    dir_rows.push_back(mk_item(MODE_ACTION, 0, 0, 0, 3'd0, CHK_SILENT, none));
    dir_rows.push_back(mk_item(MODE_ACTION, 255, 8191, 127, 3'd6, CHK_SILENT, none));
    dir_rows.push_back(mk_item(MODE_ACTION, 0, 0, 0, 3'd7, CHK_SILENT, none));
    // field extremes saturate; rate outside the band alarms
    dir_rows.push_back(mk_item(MODE_VITAL, 0, 0, 0, 3'd7, CHK_RECORD,
                               mk_rec(RATE_MIN, TEMP_MIN, OXY_MIN, 0, 1, 0, 0, PRIO_LOW)));
    dir_rows.push_back(mk_item(MODE_VITAL, 255, 8191, 127, 3'd0, CHK_RECORD,
                               mk_rec(RATE_MAX, TEMP_MAX, OXY_MAX, 0, 1, 0, 0, PRIO_LOW)));
    // in-band sample with windows not yet full: silent
    dir_rows.push_back(mk_item(MODE_VITAL, 100, 3700, 95, 3'd0, CHK_SILENT, none));
    dir_rows.push_back(mk_item(MODE_ACTION, 0, 0, 0, ACT_MANUAL, CHK_RECORD,
                               mk_rec(100, 3700, 95, 0, 0, 0, 0, PRIO_NONE)));
    // band edges; the tenth sample fills both windows, both window alarms at once
    dir_rows.push_back(mk_item(MODE_VITAL, 70, 4100, 80, 3'd0, CHK_MODEL, none));
    dir_rows.push_back(mk_item(MODE_VITAL, 71, 4100, 80, 3'd0, CHK_MODEL, none));
    dir_rows.push_back(mk_item(MODE_VITAL, 80, 4100, 80, 3'd0, CHK_MODEL, none));
    dir_rows.push_back(mk_item(MODE_VITAL, 81, 4100, 80, 3'd0, CHK_MODEL, none));
    dir_rows.push_back(mk_item(MODE_VITAL, 139, 4100, 80, 3'd0, CHK_MODEL, none));
    dir_rows.push_back(mk_item(MODE_VITAL, 140, 4100, 80, 3'd0, CHK_MODEL, none));
    dir_rows.push_back(mk_item(MODE_VITAL, 159, 4100, 80, 3'd0, CHK_MODEL, none));
    dir_rows.push_back(mk_item(MODE_VITAL, 160, 4100, 80, 3'd0, CHK_MODEL, none));
    // windows cleared by the alarm: only the heart band remains
    dir_rows.push_back(mk_item(MODE_VITAL, 200, 3500, 100, 3'd0, CHK_MODEL, none));
    dir_rows.push_back(mk_item(MODE_VITAL, 120, 3500, 100, 3'd0, CHK_MODEL, none));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      maybe_gap();
      offer(dir_rows[i]);
    end

    // random phases, each with its own settings
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: load_settings(1'b1, 1'b1, 7'd80, 13'd3500);
        1: load_settings(1'b1, 1'b0, 7'd100, 13'd4100);
        2: load_settings(1'b0, 1'b1, 7'd92, 13'd3750);
        3: load_settings(1'b1, 1'b1, OXY_W'($urandom_range(80, 100)),
                         TEMP_W'($urandom_range(3500, 4100)));
        4: load_settings(1'b1, 1'b1, 7'd127, 13'd0);
        5: load_settings(1'b1, 1'b0, 7'd0, 13'd8191);
        default: load_settings(1'b1, 1'b1, 7'd92, 13'd3750);
      endcase
      if (ph == 0) pressure_go = 1'b1;
      if (ph == N_PHASES - 1) quiet = 1'b1;
      repeat (ITEMS_PER_PH) begin
        maybe_gap();
        offer(random_item());
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/vsam_pkg.sv
rtl/core/vsam_window.sv
rtl/core/vital_sign_alarm_monitor.sv
tb/vital_sign_alarm_monitor_tb.sv
